FILE: sv/best_fit_segment_allocator_macros.svh
// Assertion macros shared by the allocator modules.
// Simulation builds get real assertions; synthesis builds get empty bodies.
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BFSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFSA_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BFSA_ASSERT(name, prop, msg)
`define BFSA_NEVER(name, expr, msg)
`endif
`endif

FILE: sv/bfsa_pkg.sv
`timescale 1ns / 1ps

package bfsa_pkg;

  // Field widths fixed by the interface.
  localparam int CFG_W    = 16;
  localparam int STATUS_W = 3;

  localparam logic [CFG_W-1:0] RESET_MEMORY = 16'd1024;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOOWNER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                cfg_load;  // capture a new memory size
    logic                init;      // write one free segment, count becomes one
    logic                load;      // capture a request, clear scan results
    logic                rd_en;     // read the table entry at the read address
    logic                scan;      // evaluate the read entry for the search
    logic                mv;        // write the read entry back at a shifted place
    logic                mv_up;     // shift toward higher indexes
    logic                mv_two;    // shift down by two entries
    logic                wr_alloc;  // write the best fit as used
    logic                wr_rem;    // write the free remainder after the best fit
    logic                wr_merge;  // write the released and merged free segment
    logic                res_load;  // load the result register
    logic                cnt_inc;
    logic                cnt_dec1;
    logic                cnt_dec2;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;    // current request is a release
    logic req_zero;   // requested size is zero
    logic found;      // a free segment fits
    logic exact;      // the best fit has exactly the requested size
    logic hit;        // a used segment of the owner was found
    logic prev_free;  // the segment before the hit is free
    logic next_free;  // the segment after the hit is free
  } stat_t;

endpackage

FILE: sv/bfsa_datapath.sv
`timescale 1ns / 1ps

`include "best_fit_segment_allocator_macros.svh"

module bfsa_datapath import bfsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 32,
  parameter int ADDR_BITS    = 16,
  parameter int OWNER_BITS   = 8,
  parameter int IW           = $clog2(MAX_SEGMENTS),
  parameter int CW           = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [IW-1:0]         rd_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_op,
  input  logic [OWNER_BITS-1:0] in_owner,
  input  logic [ADDR_BITS-1:0]  in_req,
  output stat_t                 stat,
  output logic [IW-1:0]         best_idx,
  output logic [IW-1:0]         hit_idx,
  output logic [CW-1:0]         count,
  output logic [STATUS_W-1:0]   res_status,
  output logic [ADDR_BITS-1:0]  res_start,
  output logic [ADDR_BITS-1:0]  res_size
);

  localparam int EW = OWNER_BITS + 1 + 2 * ADDR_BITS;
  localparam int MW = (ADDR_BITS > CFG_W) ? ADDR_BITS : CFG_W;
  localparam logic [ADDR_BITS-1:0] AMASK = {ADDR_BITS{1'b1}};

  // Memory sizes beyond the address range saturate.
  function automatic logic [ADDR_BITS-1:0] sat_mem(input logic [CFG_W-1:0] v);
    logic [MW-1:0] ext;
    ext = MW'(v);
    if (ext > MW'(AMASK)) begin
      return AMASK;
    end
    return ext[ADDR_BITS-1:0];
  endfunction

  // Segment table: {owner, used, size, start} per entry.
  logic [EW-1:0] ent_mem [MAX_SEGMENTS];

  logic [ADDR_BITS-1:0]  total;
  logic                  op_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [ADDR_BITS-1:0]  req_q;

  logic [EW-1:0]         rd_data;
  logic [IW-1:0]         rd_idx;
  logic                  sc_q;
  logic                  mv_q;
  logic                  mv_up_q;
  logic                  mv_two_q;

  logic                  found;
  logic [ADDR_BITS-1:0]  best_start;
  logic [ADDR_BITS-1:0]  best_size;
  logic                  hit;
  logic [ADDR_BITS-1:0]  hit_start;
  logic [ADDR_BITS-1:0]  hit_size;
  logic                  need_next;
  logic                  prev_free;
  logic [ADDR_BITS-1:0]  prev_start;
  logic [ADDR_BITS-1:0]  prev_size;
  logic                  next_free;
  logic [ADDR_BITS-1:0]  next_size;
  logic                  last_used;
  logic [ADDR_BITS-1:0]  last_start;
  logic [ADDR_BITS-1:0]  last_size;

  logic [ADDR_BITS-1:0]  e_start;
  logic [ADDR_BITS-1:0]  e_size;
  logic                  e_used;
  logic [OWNER_BITS-1:0] e_owner;

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic [IW-1:0]         m_addr;
  logic [ADDR_BITS-1:0]  m_start;
  logic [ADDR_BITS-1:0]  m_size;
  logic [ADDR_BITS-1:0]  n_add;

  assign e_start = rd_data[ADDR_BITS-1:0];
  assign e_size  = rd_data[2*ADDR_BITS-1:ADDR_BITS];
  assign e_used  = rd_data[2*ADDR_BITS];
  assign e_owner = rd_data[EW-1:2*ADDR_BITS+1];

  // Memory size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= sat_mem(RESET_MEMORY);
    end else if (cmd.cfg_load) begin
      total <= sat_mem(cfg_data);
    end
  end

  // Table read port and the flags that travel with the read data.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= ent_mem[rd_addr];
    end
    rd_idx   <= rd_addr;
    mv_up_q  <= cmd.mv_up;
    mv_two_q <= cmd.mv_two;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_q <= 1'b0;
      mv_q <= 1'b0;
    end else begin
      sc_q <= cmd.rd_en && cmd.scan;
      mv_q <= cmd.rd_en && cmd.mv;
    end
  end

  // Merged free segment for a release.
  always_comb begin
    n_add = next_free ? next_size : '0;
    if (prev_free) begin
      m_addr  = hit_idx - IW'(1);
      m_start = prev_start;
      m_size  = prev_size + hit_size + n_add;
    end else begin
      m_addr  = hit_idx;
      m_start = hit_start;
      m_size  = hit_size + n_add;
    end
  end

  // Table write port.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    priority if (cmd.init) begin
      wr_data = {OWNER_BITS'(0), 1'b0, total, ADDR_BITS'(0)};
    end else if (mv_q) begin
      wr_addr = mv_up_q ? rd_idx + IW'(1) : rd_idx - (mv_two_q ? IW'(2) : IW'(1));
      wr_data = rd_data;
    end else if (cmd.wr_alloc) begin
      wr_addr = best_idx;
      wr_data = {owner_q, 1'b1, req_q, best_start};
    end else if (cmd.wr_rem) begin
      wr_addr = best_idx + IW'(1);
      wr_data = {OWNER_BITS'(0), 1'b0, best_size - req_q, best_start + req_q};
    end else if (cmd.wr_merge) begin
      wr_addr = m_addr;
      wr_data = {OWNER_BITS'(0), 1'b0, m_size, m_start};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_data;
    end
  end

  // Segment count.
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      count <= CW'(1);
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec1) begin
      count <= count - CW'(1);
    end else if (cmd.cnt_dec2) begin
      count <= count - CW'(2);
    end
  end

  // Request capture and the search over the table.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= in_op;
      owner_q   <= in_owner;
      req_q     <= in_req;
      found     <= 1'b0;
      hit       <= 1'b0;
      need_next <= 1'b0;
      prev_free <= 1'b0;
      next_free <= 1'b0;
      last_used <= 1'b1;
    end else if (sc_q) begin
      last_used  <= e_used;
      last_start <= e_start;
      last_size  <= e_size;
      if (op_q == OP_ALLOC) begin
        if (!e_used && e_size >= req_q && (!found || e_size < best_size)) begin
          found      <= 1'b1;
          best_idx   <= rd_idx;
          best_start <= e_start;
          best_size  <= e_size;
        end
      end else if (!hit && e_used && e_owner == owner_q) begin
        hit        <= 1'b1;
        hit_idx    <= rd_idx;
        hit_start  <= e_start;
        hit_size   <= e_size;
        prev_free  <= !last_used;
        prev_start <= last_start;
        prev_size  <= last_size;
        need_next  <= 1'b1;
      end else if (need_next) begin
        need_next <= 1'b0;
        next_free <= !e_used;
        next_size <= e_size;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      if (cmd.res_status != ST_OK) begin
        res_start <= '0;
        res_size  <= '0;
      end else if (op_q == OP_ALLOC) begin
        res_start <= best_start;
        res_size  <= req_q;
      end else begin
        res_start <= hit_start;
        res_size  <= hit_size;
      end
    end
  end

  assign stat.is_free   = (op_q == OP_FREE);
  assign stat.req_zero  = (req_q == '0);
  assign stat.found     = found;
  assign stat.exact     = (best_size == req_q);
  assign stat.hit       = hit;
  assign stat.prev_free = prev_free;
  assign stat.next_free = next_free;

  `BFSA_ASSERT(a_count_range, count != '0 && count <= CW'(MAX_SEGMENTS), "count out of range")
  `BFSA_ASSERT(a_alloc_found, cmd.wr_alloc |-> found && !stat.is_free, "alloc without fit")
  `BFSA_ASSERT(a_merge_hit, cmd.wr_merge |-> hit && stat.is_free, "merge without owner hit")

endmodule

FILE: sv/bfsa_ctrl.sv
`timescale 1ns / 1ps

`include "best_fit_segment_allocator_macros.svh"

module bfsa_ctrl import bfsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 32,
  parameter int IW           = $clog2(MAX_SEGMENTS),
  parameter int CW           = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  stat_t         stat,
  input  logic [IW-1:0] best_idx,
  input  logic [IW-1:0] hit_idx,
  input  logic [CW-1:0] count,
  output cmd_t          cmd,
  output logic [IW-1:0] rd_addr
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SHUP   = 4'd5;
  localparam logic [3:0] S_SHDN   = 4'd6;
  localparam logic [3:0] S_SDRAIN = 4'd7;
  localparam logic [3:0] S_WR2    = 4'd8;
  localparam logic [3:0] S_WR1    = 4'd9;
  localparam logic [3:0] S_RESP   = 4'd10;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [IW-1:0]       ptr;
  logic [IW-1:0]       ptr_next;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] code_next;
  logic [CW:0]         sh_start;
  logic [CW:0]         best_up;
  logic [CW-1:0]       last_idx;

  assign last_idx = count - CW'(1);
  assign best_up  = (CW + 1)'(best_idx) + (CW + 1)'(1);
  assign sh_start = (CW + 1)'(hit_idx) + (CW + 1)'(1) + (CW + 1)'(stat.next_free);
  assign rd_addr  = ptr;

  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  // Sequencer for search, table shift and final writes.
  always_comb begin
    cmd        = '0;
    state_next = state;
    ptr_next   = ptr;
    code_next  = code;
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_load = 1'b1;
          state_next   = S_INIT;
        end else if (s_tvalid) begin
          cmd.load   = 1'b1;
          ptr_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.scan  = 1'b1;
        ptr_next  = ptr + IW'(1);
        if (CW'(ptr) == last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.is_free) begin
          priority if (stat.req_zero) begin
            code_next  = ST_ZERO;
            state_next = S_RESP;
          end else if (!stat.found) begin
            code_next  = ST_NOFIT;
            state_next = S_RESP;
          end else if (stat.exact) begin
            code_next  = ST_OK;
            state_next = S_WR1;
          end else if (count == CW'(MAX_SEGMENTS)) begin
            code_next  = ST_FULL;
            state_next = S_RESP;
          end else if (best_up < (CW + 1)'(count)) begin
            code_next  = ST_OK;
            ptr_next   = last_idx[IW-1:0];
            state_next = S_SHUP;
          end else begin
            code_next  = ST_OK;
            state_next = S_WR2;
          end
        end else if (!stat.hit) begin
          code_next  = ST_NOOWNER;
          state_next = S_RESP;
        end else begin
          code_next    = ST_OK;
          cmd.wr_merge = 1'b1;
          if ((stat.prev_free || stat.next_free) && sh_start < (CW + 1)'(count)) begin
            ptr_next   = sh_start[IW-1:0];
            state_next = S_SHDN;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SHUP: begin
        cmd.rd_en = 1'b1;
        cmd.mv    = 1'b1;
        cmd.mv_up = 1'b1;
        ptr_next  = ptr - IW'(1);
        if ((CW + 1)'(ptr) == best_up) begin
          state_next = S_SDRAIN;
        end
      end
      S_SHDN: begin
        cmd.rd_en  = 1'b1;
        cmd.mv     = 1'b1;
        cmd.mv_two = stat.prev_free && stat.next_free;
        ptr_next   = ptr + IW'(1);
        if (CW'(ptr) == last_idx) begin
          state_next = S_SDRAIN;
        end
      end
      S_SDRAIN: begin
        state_next = stat.is_free ? S_RESP : S_WR2;
      end
      S_WR2: begin
        cmd.wr_rem = 1'b1;
        state_next = S_WR1;
      end
      S_WR1: begin
        cmd.wr_alloc = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (!m_tvalid || m_tready) begin
          cmd.res_load = 1'b1;
          if (code == ST_OK) begin
            if (!stat.is_free) begin
              cmd.cnt_inc = !stat.exact;
            end else begin
              cmd.cnt_dec1 = stat.prev_free ^ stat.next_free;
              cmd.cnt_dec2 = stat.prev_free && stat.next_free;
            end
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.res_status = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    code <= code_next;
  end

  // Output valid: set on a result load, cleared once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `BFSA_ASSERT(a_accept_scan, s_tvalid && s_tready |=> state == S_SCAN, "accept not followed by scan")
  `BFSA_NEVER(a_res_overwrite, cmd.res_load && m_tvalid && !m_tready, "result overwritten")
  `BFSA_NEVER(a_cfg_busy, cmd.cfg_load && state != S_IDLE, "config taken while busy")

endmodule

FILE: sv/best_fit_segment_allocator.sv
`timescale 1ns / 1ps
// A request scans every table segment from input transfer to result, and entries may
// shift as well for a split or a merge.
// Throughput: one request at a time; the next is taken once the result register is loaded.
// Reset (synchronous, active high) and each memory size write rebuild the table in the
// init state as a single free segment; no input is taken while in that state.
module best_fit_segment_allocator import bfsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 32,
  parameter int ADDR_BITS    = 16,
  parameter int OWNER_BITS   = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // owner_id, req_size (from bit 0 up)
  input  logic [((OWNER_BITS+ADDR_BITS+7)/8)*8-1:0] s_tdata,
  // opcode
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status, block_start, block_size (from bit 0 up)
  output logic [((STATUS_W+2*ADDR_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int IW    = $clog2(MAX_SEGMENTS);
  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int OUT_W = ((STATUS_W + 2 * ADDR_BITS + 7) / 8) * 8;

  cmd_t                 cmd;
  stat_t                stat;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        best_idx;
  logic [IW-1:0]        hit_idx;
  logic [CW-1:0]        count;
  logic [STATUS_W-1:0]  res_status;
  logic [ADDR_BITS-1:0] res_start;
  logic [ADDR_BITS-1:0] res_size;

  bfsa_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .stat     (stat),
    .best_idx (best_idx),
    .hit_idx  (hit_idx),
    .count    (count),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  bfsa_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .ADDR_BITS   (ADDR_BITS),
    .OWNER_BITS  (OWNER_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .cfg_data  (cfg_data),
    .in_op     (s_tuser),
    .in_owner  (s_tdata[OWNER_BITS-1:0]),
    .in_req    (s_tdata[OWNER_BITS+ADDR_BITS-1:OWNER_BITS]),
    .stat      (stat),
    .best_idx  (best_idx),
    .hit_idx   (hit_idx),
    .count     (count),
    .res_status(res_status),
    .res_start (res_start),
    .res_size  (res_size)
  );

  // Pack the result fields, zero filled to whole bytes.
  assign m_tdata = OUT_W'({res_size, res_start, res_status});

endmodule

FILE: test/tb_best_fit_segment_allocator.sv
`timescale 1ns / 1ps
module tb_best_fit_segment_allocator;
  import bfsa_pkg::*;

  localparam int SEGS = 32;

  typedef struct packed {
    logic        op;
    logic [7:0]  owner;
    logic [15:0] size;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start;
    logic [15:0] size;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  best_fit_segment_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  int       accepted_count = 0;
  int       sender_idle_pct = 23;
  int       receiver_idle_pct = 62;
  bit       failed = 1'b0;
  int       mem_now = 1024;

  // Segment table mirrored by the predictor.
  logic [15:0] seg_base[SEGS];
  logic [15:0] seg_len[SEGS];
  bit          seg_busy[SEGS];
  logic [7:0]  seg_tag[SEGS];
  int          seg_num;

  function automatic void table_rebuild(logic [15:0] mem_size);
    for (int i = 0; i < SEGS; i++) begin
      seg_base[i] = '0;
      seg_len[i]  = '0;
      seg_busy[i] = 1'b0;
      seg_tag[i]  = '0;
    end
    seg_len[0] = mem_size;
    seg_num = 1;
  endfunction

  function automatic reply_t serve_request(request_t r);
    reply_t res;
    int best;
    logic [15:0] s;
    logic [15:0] z;
    best = -1;
    res = '{status: ST_OK, start: 16'd0, size: 16'd0};
    if (r.op == OP_ALLOC) begin
      if (r.size == 0) begin
        res.status = ST_ZERO;
        return res;
      end
      for (int i = 0; i < seg_num; i++)
        if (!seg_busy[i] && seg_len[i] >= r.size && (best < 0 || seg_len[i] < seg_len[best]))
          best = i;
      if (best < 0) begin
        res.status = ST_NOFIT;
        return res;
      end
      if (seg_len[best] != r.size) begin
        if (seg_num >= SEGS) begin
          res.status = ST_FULL;
          return res;
        end
        // Open a slot after the best fit for the free remainder.
        for (int k = seg_num; k > best + 1; k--) begin
          seg_base[k] = seg_base[k-1];
          seg_len[k]  = seg_len[k-1];
          seg_busy[k] = seg_busy[k-1];
          seg_tag[k]  = seg_tag[k-1];
        end
        seg_base[best+1] = seg_base[best] + r.size;
        seg_len[best+1]  = seg_len[best] - r.size;
        seg_busy[best+1] = 1'b0;
        seg_tag[best+1]  = '0;
        seg_len[best]    = r.size;
        seg_num++;
      end
      seg_busy[best] = 1'b1;
      seg_tag[best]  = r.owner;
      res.start = seg_base[best];
      res.size  = seg_len[best];
      return res;
    end
    for (int i = 0; i < seg_num; i++) begin
      if (seg_busy[i] && seg_tag[i] == r.owner) begin
        s = seg_base[i];
        z = seg_len[i];
        seg_busy[i] = 1'b0;
        seg_tag[i]  = '0;
        // Merge runs of adjacent free segments.
        best = 0;
        while (best + 1 < seg_num) begin
          if (!seg_busy[best] && !seg_busy[best+1]) begin
            seg_len[best] += seg_len[best+1];
            for (int k = best + 1; k + 1 < seg_num; k++) begin
              seg_base[k] = seg_base[k+1];
              seg_len[k]  = seg_len[k+1];
              seg_busy[k] = seg_busy[k+1];
              seg_tag[k]  = seg_tag[k+1];
            end
            seg_num--;
          end else begin
            best++;
          end
        end
        res.start = s;
        res.size  = z;
        return res;
      end
    end
    res.status = ST_NOOWNER;
    return res;
  endfunction

  // Random request: mostly small sizes and a few owners so that the table fills up.
  function automatic request_t random_request();
    request_t r;
    int pick;
    r.op = ($urandom_range(0, 99) < 40) ? OP_FREE : OP_ALLOC;
    r.owner = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 70)      r.size = 16'($urandom_range(1, mem_now / 24 + 1));
    else if (pick < 78) r.size = '0;
    else if (pick < 88) r.size = 16'($urandom);
    else                r.size = 16'($urandom_range(1, mem_now > 0 ? mem_now : 1));
    return r;
  endfunction

  // Input driver: holds an item until its transfer, idles at random.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_replies.push_back(serve_request(pending_requests.pop_front()));
        accepted_count++;
        if (accepted_count == 250) begin
          sender_idle_pct = 62;
          receiver_idle_pct = 23;
        end else if (accepted_count == 500) begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      end
      if (pending_requests.size() > 0 &&
          ((s_tvalid && !s_tready) || $urandom_range(0, 99) >= sender_idle_pct)) begin
        s_tvalid <= 1'b1;
        s_tuser  <= pending_requests[0].op;
        s_tdata  <= {pending_requests[0].size, pending_requests[0].owner};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor: compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result transfer %h", m_tdata);
          failed = 1'b1;
        end else begin
          want = expected_replies.pop_front();
          if (m_tdata[2:0] !== want.status) begin
            $error("status expected %0d actual %0d", want.status, m_tdata[2:0]);
            failed = 1'b1;
          end
          if (m_tdata[18:3] !== want.start) begin
            $error("block_start expected %0d actual %0d", want.start, m_tdata[18:3]);
            failed = 1'b1;
          end
          if (m_tdata[34:19] !== want.size) begin
            $error("block_size expected %0d actual %0d", want.size, m_tdata[34:19]);
            failed = 1'b1;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  task automatic push_req(logic op, logic [7:0] owner, logic [15:0] size);
    request_t r;
    r.op = op;
    r.owner = owner;
    r.size = size;
    pending_requests.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_replies.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_memory_size(logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mem_now = value;
    table_rebuild(value);
  endtask

  initial begin
    int sizes[5] = '{65535, 200, 1, 4096, 1024};
    table_rebuild(RESET_MEMORY);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed checks on the reset memory size.
    push_req(OP_ALLOC, 8'd9, 16'd0);
    push_req(OP_ALLOC, 8'd9, 16'hFFFF);
    push_req(OP_FREE, 8'd7, 16'hFFFF);
    push_req(OP_ALLOC, 8'd1, 16'd100);
    push_req(OP_ALLOC, 8'd2, 16'd200);
    push_req(OP_ALLOC, 8'd3, 16'd724);
    push_req(OP_ALLOC, 8'd4, 16'd1);
    push_req(OP_FREE, 8'd2, 16'd0);
    push_req(OP_FREE, 8'd1, 16'd0);
    push_req(OP_FREE, 8'd3, 16'd0);
    push_req(OP_ALLOC, 8'hFF, 16'd1024);
    push_req(OP_FREE, 8'hFF, 16'd0);
    wait_drained();

    // An empty memory fits nothing.
    write_memory_size(16'd0);
    push_req(OP_ALLOC, 8'd5, 16'd1);
    push_req(OP_ALLOC, 8'd5, 16'd0);
    push_req(OP_FREE, 8'd5, 16'd0);
    wait_drained();

    // Largest memory, allocated whole.
    write_memory_size(16'hFFFF);
    push_req(OP_ALLOC, 8'hAA, 16'hFFFF);
    push_req(OP_FREE, 8'hAA, 16'd0);
    wait_drained();

    // Random phases over several memory sizes.
    foreach (sizes[p]) begin
      write_memory_size(16'(sizes[p]));
      repeat (140) pending_requests.push_back(random_request());
      wait_drained();
    end

    if (!failed && expected_replies.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
